// ----- design/refcounted_handle_table_top_macros.svh -----
// Assertion macros for the handle table top level.
// Expects signals named clk and rst_n in the including scope.
`ifndef REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH
`define REFCOUNTED_HANDLE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rht_pkg.sv -----
// Shared codes, widths and state type for the reference-counted handle table.
// No dependencies.
`default_nettype none

package rht_pkg;

  localparam int REQ_W       = 3;
  localparam int STAT_W      = 3;
  localparam int DESC_W      = 32;
  localparam int HOUT_W      = 6;
  localparam int PRESET_SLOTS = 3;

  localparam logic [DESC_W-1:0] DESC_NONE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 3'd0,
    REQ_GET     = 3'd1,
    REQ_ACQUIRE = 3'd2,
    REQ_CLOSE   = 3'd3,
    REQ_RETAIN  = 3'd4,
    REQ_RELEASE = 3'd5
  } rht_req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_RANGE     = 3'd1,
    STAT_NOT_LIVE  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_LIMIT     = 3'd4,
    STAT_NO_REFS   = 3'd5
  } rht_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } rht_state_t;

endpackage

`default_nettype wire

// ----- design/rht_slot_mem.sv -----
// Slot memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module rht_slot_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 49
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] slot_mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem_r[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= slot_mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/refcounted_handle_table_top.sv -----
// Reference-counted handle table: request sequencer around the slot memory.
// Depends on rht_pkg, rht_slot_mem and refcounted_handle_table_top_macros.svh.
//
//   channel | ports                                        | direction
//   in      | in_valid/in_stall, req_type, handle, desc    | request in
//   out     | out_valid/out_stall, status, handle_out, ... | result out
//
// Every request but a reusing add is accepted with a memory read in ST_IDLE, then
// modified and written back in ST_EXEC. Once the fresh slots are used up, an add scans the
// slot memory from slot 0 in ST_SCAN, one entry per cycle, up to a free slot or the last one.
// After reset a clearing pass over every slot loads the initial slots;
// no request is taken meanwhile. A result waits in the output register while
// the next request is accepted; execution holds while that register is full and out_stall is high.
`default_nettype none
`include "refcounted_handle_table_top_macros.svh"

module refcounted_handle_table_top #(
  parameter int TABLE_SLOTS = 64,
  parameter int REF_BITS    = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [rht_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic        [15:0]                 in_handle,
  input  wire logic signed [rht_pkg::DESC_W-1:0]  in_desc_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [rht_pkg::STAT_W-1:0]  out_status,
  output logic             [rht_pkg::HOUT_W-1:0]  out_handle_out,
  output logic signed      [rht_pkg::DESC_W-1:0]  out_desc_out,
  output logic                                    out_close_now,
  output logic signed      [rht_pkg::DESC_W-1:0]  out_close_desc
);

  localparam int AW      = $clog2(TABLE_SLOTS);
  localparam int PW      = $clog2(TABLE_SLOTS + 1);
  localparam int DW      = rht_pkg::DESC_W;
  localparam int ENTRY_W = 1 + DW + REF_BITS;

  rht_pkg::rht_state_t state_r, state_nxt;

  logic [AW-1:0]              clr_idx_r, clr_idx_nxt;
  logic [PW-1:0]              fresh_ptr_r, fresh_ptr_nxt;
  logic [AW-1:0]              scan_idx_r, scan_idx_nxt;
  logic [rht_pkg::REQ_W-1:0]  req_r;
  logic [AW-1:0]              slot_r;
  logic [DW-1:0]              desc_r;
  logic                       err_r;

  logic                       out_valid_r;
  logic [rht_pkg::STAT_W-1:0] status_r;
  logic [rht_pkg::HOUT_W-1:0] hout_r;
  logic [DW-1:0]              desc_out_r;
  logic                       close_now_r;
  logic [DW-1:0]              close_desc_r;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]         mem_wdata, rd_data;

  logic                       rd_live;
  logic [DW-1:0]              rd_desc;
  logic [REF_BITS-1:0]        rd_refs, refs_dec, refs_inc;

  logic                       in_acc, fresh_done, out_room, scan_free, scan_last, clr_last;
  logic                       req_err;

  logic                       ex_wr;
  logic [ENTRY_W-1:0]         ex_wdata;
  rht_pkg::rht_status_t       ex_status;
  logic [rht_pkg::HOUT_W-1:0] ex_hout;
  logic [DW-1:0]              ex_desc_out;
  logic                       ex_close;
  logic [DW-1:0]              ex_close_desc;

  logic                       res_load;
  rht_pkg::rht_status_t       res_status;
  logic [rht_pkg::HOUT_W-1:0] res_hout;
  logic [DW-1:0]              res_desc_out;
  logic                       res_close;
  logic [DW-1:0]              res_close_desc;
  logic [ENTRY_W-1:0]         clr_wdata;

  rht_slot_mem #(
    .DEPTH(TABLE_SLOTS),
    .WIDTH(ENTRY_W)
  ) u_slot_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  assign rd_live  = rd_data[ENTRY_W-1];
  assign rd_desc  = rd_data[REF_BITS +: DW];
  assign rd_refs  = rd_data[REF_BITS-1:0];
  assign refs_dec = (rd_refs == '0) ? '0 : rd_refs - REF_BITS'(1);
  assign refs_inc = rd_refs + REF_BITS'(1);

  assign in_acc     = in_valid && !in_stall;
  assign fresh_done = (fresh_ptr_r == PW'(TABLE_SLOTS));
  assign out_room   = !out_valid_r || !out_stall;
  assign scan_free  = !rd_live && (rd_refs == '0);
  assign scan_last  = (scan_idx_r == AW'(TABLE_SLOTS - 1));
  assign clr_last   = (clr_idx_r == AW'(TABLE_SLOTS - 1));
  assign req_err    = (in_req_type > rht_pkg::REQ_RELEASE) ||
                      ((in_req_type != rht_pkg::REQ_ADD) && (in_handle >= 16'(TABLE_SLOTS)));

  assign clr_wdata = (clr_idx_r < AW'(rht_pkg::PRESET_SLOTS)) ?
                     {1'b1, DW'(clr_idx_r), REF_BITS'(1)} : '0;

  // Modify step for a request whose slot was read in the accept cycle.
  always_comb begin
    ex_wr         = 1'b0;
    ex_wdata      = rd_data;
    ex_status     = rht_pkg::STAT_OK;
    ex_hout       = '0;
    ex_desc_out   = '0;
    ex_close      = 1'b0;
    ex_close_desc = '0;
    if (err_r) begin
      ex_status = rht_pkg::STAT_RANGE;
      if ((req_r == rht_pkg::REQ_GET) || (req_r == rht_pkg::REQ_ACQUIRE)) begin
        ex_desc_out = rht_pkg::DESC_NONE;
      end
    end else begin
      unique case (req_r)
        rht_pkg::REQ_ADD: begin
          ex_wr    = 1'b1;
          ex_wdata = {1'b1, desc_r, REF_BITS'(1)};
          ex_hout  = rht_pkg::HOUT_W'(slot_r);
        end
        rht_pkg::REQ_GET: begin
          if (!rd_live) begin
            ex_status   = rht_pkg::STAT_NOT_LIVE;
            ex_desc_out = rht_pkg::DESC_NONE;
          end else begin
            ex_desc_out = rd_desc;
          end
        end
        rht_pkg::REQ_ACQUIRE, rht_pkg::REQ_RETAIN: begin
          if (!rd_live) begin
            ex_status = rht_pkg::STAT_NOT_LIVE;
            if (req_r == rht_pkg::REQ_ACQUIRE) ex_desc_out = rht_pkg::DESC_NONE;
          end else if (rd_refs == '1) begin
            ex_status = rht_pkg::STAT_LIMIT;
            if (req_r == rht_pkg::REQ_ACQUIRE) ex_desc_out = rht_pkg::DESC_NONE;
          end else begin
            ex_wr    = 1'b1;
            ex_wdata = {rd_live, rd_desc, refs_inc};
            if (req_r == rht_pkg::REQ_ACQUIRE) ex_desc_out = rd_desc;
          end
        end
        rht_pkg::REQ_CLOSE: begin
          if (!rd_live) begin
            ex_status = rht_pkg::STAT_NOT_LIVE;
          end else begin
            ex_wr = 1'b1;
            if (refs_dec == '0) begin
              ex_wdata      = {1'b0, rht_pkg::DESC_NONE, REF_BITS'(0)};
              ex_close      = 1'b1;
              ex_close_desc = rd_desc;
            end else begin
              ex_wdata = {1'b0, rd_desc, refs_dec};
            end
          end
        end
        rht_pkg::REQ_RELEASE: begin
          if (rd_refs == '0) begin
            ex_status = rht_pkg::STAT_NO_REFS;
          end else begin
            ex_wr = 1'b1;
            if (refs_dec == '0) begin
              ex_wdata      = {1'b0, rht_pkg::DESC_NONE, REF_BITS'(0)};
              ex_close      = 1'b1;
              ex_close_desc = rd_desc;
            end else begin
              ex_wdata = {rd_live, rd_desc, refs_dec};
            end
          end
        end
        default: begin
          ex_status = rht_pkg::STAT_RANGE;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rht_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = rht_pkg::ST_IDLE;
      end
      rht_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == rht_pkg::REQ_ADD && fresh_done) begin
            state_nxt = rht_pkg::ST_SCAN;
          end else begin
            state_nxt = rht_pkg::ST_EXEC;
          end
        end
      end
      rht_pkg::ST_EXEC: begin
        if (out_room) state_nxt = rht_pkg::ST_IDLE;
      end
      rht_pkg::ST_SCAN: begin
        if ((scan_free || scan_last) && out_room) state_nxt = rht_pkg::ST_IDLE;
      end
      default: state_nxt = rht_pkg::ST_IDLE;
    endcase
  end

  // Memory control and result selection.
  always_comb begin
    in_stall       = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = slot_r;
    mem_wdata      = ex_wdata;
    mem_re         = 1'b0;
    mem_raddr      = in_handle[AW-1:0];
    res_load       = 1'b0;
    res_status     = ex_status;
    res_hout       = ex_hout;
    res_desc_out   = ex_desc_out;
    res_close      = ex_close;
    res_close_desc = ex_close_desc;
    unique case (state_r)
      rht_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = clr_wdata;
      end
      rht_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        mem_re   = in_valid;
        if (in_req_type == rht_pkg::REQ_ADD) mem_raddr = '0;
      end
      rht_pkg::ST_EXEC: begin
        if (out_room) begin
          res_load = 1'b1;
          mem_we   = ex_wr;
        end
      end
      rht_pkg::ST_SCAN: begin
        res_desc_out   = '0;
        res_close      = 1'b0;
        res_close_desc = '0;
        res_hout       = '0;
        if (scan_free) begin
          res_status = rht_pkg::STAT_OK;
          res_hout   = rht_pkg::HOUT_W'(scan_idx_r);
          if (out_room) begin
            res_load  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = scan_idx_r;
            mem_wdata = {1'b1, desc_r, REF_BITS'(1)};
          end
        end else if (scan_last) begin
          res_status = rht_pkg::STAT_FULL;
          res_load   = out_room;
        end else begin
          // Advance the scan read to the next slot.
          mem_re    = 1'b1;
          mem_raddr = scan_idx_r + AW'(1);
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    fresh_ptr_nxt = fresh_ptr_r;
    scan_idx_nxt  = scan_idx_r;
    if (state_r == rht_pkg::ST_CLEAR) clr_idx_nxt = clr_idx_r + AW'(1);
    if (in_acc) begin
      scan_idx_nxt = '0;
      if (in_req_type == rht_pkg::REQ_ADD && !fresh_done) begin
        fresh_ptr_nxt = fresh_ptr_r + PW'(1);
      end
    end else if (state_r == rht_pkg::ST_SCAN && mem_re) begin
      scan_idx_nxt = scan_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rht_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      fresh_ptr_r <= PW'(rht_pkg::PRESET_SLOTS);
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      fresh_ptr_r <= fresh_ptr_nxt;
      scan_idx_r  <= scan_idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request; the slot is the handle or the next fresh slot.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req_type;
      desc_r <= in_desc_value;
      err_r  <= req_err;
      if (in_req_type == rht_pkg::REQ_ADD) begin
        slot_r <= fresh_ptr_r[AW-1:0];
      end else begin
        slot_r <= in_handle[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r     <= res_status;
      hout_r       <= res_hout;
      desc_out_r   <= res_desc_out;
      close_now_r  <= res_close;
      close_desc_r <= res_close_desc;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_handle_out = hout_r;
  assign out_desc_out   = desc_out_r;
  assign out_close_now  = close_now_r;
  assign out_close_desc = close_desc_r;

  `RHT_ASSERT_IMPL(a_fresh_bound, 1'b1, fresh_ptr_r <= PW'(TABLE_SLOTS), "fresh pointer overran")
  `RHT_ASSERT_IMPL(a_idle_no_write, state_r == rht_pkg::ST_IDLE, !mem_we, "write while idle")
  `RHT_ASSERT_IMPL(a_scan_full, state_r == rht_pkg::ST_SCAN, fresh_done, "scan with fresh slots")
  `RHT_ASSERT_NEXT(a_scan_step, state_r == rht_pkg::ST_SCAN && mem_re, scan_idx_r == $past(scan_idx_r) + AW'(1), "scan skipped a slot")

endmodule

`default_nettype wire
